### hw/rtl/iolh_pkg.sv
// ----------------------------------------------------------------------------
// iolh_pkg: shared definitions of the I/O latency histogram
// Field widths, default sizes, status and mode codes, sequencer states and
// the layout of one start record.
// ----------------------------------------------------------------------------
package iolh_pkg;

    localparam int TAG_COUNT_DEF    = 256;
    localparam int DEVICE_SLOTS_DEF = 16;
    localparam int BUCKET_COUNT_DEF = 32;
    localparam int COUNT_WIDTH_DEF  = 48;

    localparam int TIME_W      = 48;
    localparam int MAJOR_W     = 12;
    localparam int MINOR_W     = 20;
    localparam int DEVICE_W    = MAJOR_W + MINOR_W;
    localparam int BYTES_W     = 32;
    localparam int OP_W        = 32;
    localparam int VALUE_W     = 48;
    localparam int TAG_IN_W    = 8;
    localparam int SLOT_IN_W   = 4;
    localparam int BUCKET_IN_W = 5;

    localparam logic [TIME_W-1:0] NS_PER_US = 48'd1000;

    localparam logic [7:0] OP_READ  = 8'h00;
    localparam logic [7:0] OP_WRITE = 8'h01;

    typedef enum logic [1:0] {
        MODE_ISSUE    = 2'd0,
        MODE_COMPLETE = 2'd1,
        MODE_READ     = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ST_STARTED   = 3'd0,
        ST_IGNORED   = 3'd1,
        ST_NO_START  = 3'd2,
        ST_PARTIAL   = 3'd3,
        ST_COUNTED   = 3'd4,
        ST_FULL      = 3'd5,
        ST_READ_DONE = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        FSM_CLEAR,
        FSM_IDLE,
        FSM_LOOKUP,
        FSM_SCAN,
        FSM_COUNT,
        FSM_FINISH
    } fsm_t;

    typedef struct packed {
        logic                valid;
        logic                direction;
        logic [DEVICE_W-1:0] device;
        logic [TIME_W-1:0]   start_ns;
    } start_rec_t;

endpackage

### hw/rtl/io_latency_log2_histogram.sv
// ----------------------------------------------------------------------------
// io_latency_log2_histogram: request latency monitor with a log2 histogram
// Tracks issue and completion of requests by tag and counts completed
// latencies per device, direction and power-of-two microsecond bucket.
// ----------------------------------------------------------------------------
// One result per accepted transaction. Each transaction reads the start
// table; a completion that holds a full record then searches the slot table,
// and one that finds a slot does a read-modify-write of the histogram, all
// done one after the other. The next transaction is taken when the result
// is loaded into the output register and is worked on while that result
// waits there. After reset the block sweeps both tables to zero, over
// max(TAG_COUNT, 2 * DEVICE_SLOTS * BUCKET_COUNT) addresses (1024 by
// default); in_ready stays low until the sweep is done.
module io_latency_log2_histogram
    import iolh_pkg::*;
#(
    parameter int TAG_COUNT    = TAG_COUNT_DEF,
    parameter int DEVICE_SLOTS = DEVICE_SLOTS_DEF,
    parameter int BUCKET_COUNT = BUCKET_COUNT_DEF,
    parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             mode,
    input  logic [TAG_IN_W-1:0]    request_tag,
    input  logic [OP_W-1:0]        op_flags,
    input  logic [MAJOR_W-1:0]     device_major,
    input  logic [MINOR_W-1:0]     device_minor,
    input  logic [TIME_W-1:0]      time_ns,
    input  logic [BYTES_W-1:0]     completed_bytes,
    input  logic [BYTES_W-1:0]     remaining_bytes,
    input  logic [SLOT_IN_W-1:0]   read_slot,
    input  logic                   read_direction,
    input  logic [BUCKET_IN_W-1:0] read_bucket,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [2:0]             status,
    output logic [BUCKET_IN_W-1:0] bucket_index,
    output logic [VALUE_W-1:0]     count_value,
    output logic                   slot_in_use,
    output logic [MAJOR_W-1:0]     slot_major,
    output logic [MINOR_W-1:0]     slot_minor
);

    localparam int TAG_AW     = $clog2(TAG_COUNT);
    localparam int SLOT_W     = (DEVICE_SLOTS > 1) ? $clog2(DEVICE_SLOTS) : 1;
    localparam int BUCKET_W   = $clog2(BUCKET_COUNT);
    localparam int HIST_DEPTH = DEVICE_SLOTS * 2 * BUCKET_COUNT;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int CLR_DEPTH  = (TAG_COUNT > HIST_DEPTH) ? TAG_COUNT : HIST_DEPTH;
    localparam int CLR_W      = $clog2(CLR_DEPTH);
    localparam int REC_W      = $bits(start_rec_t);
    localparam int TAG_RANGE  = 2 ** TAG_IN_W;

    function automatic logic [HIST_AW-1:0] hist_index(
        input logic [SLOT_W-1:0]   slot,
        input logic                dir,
        input logic [BUCKET_W-1:0] bucket
    );
        logic [HIST_AW-1:0] row;
        row = HIST_AW'({slot, dir});
        return row * HIST_AW'(BUCKET_COUNT) + HIST_AW'(bucket);
    endfunction

    // Sequencer and handshake
    fsm_t               state_reg, state_next;
    logic [CLR_W-1:0]   clr_addr_reg;
    logic               accept;
    logic               out_free;
    logic               load_out;
    logic               ready_c;

    // Tables
    logic                   start_we;
    logic [TAG_AW-1:0]      start_waddr;
    start_rec_t             start_wdata;
    start_rec_t             start_rdata;
    logic [TAG_AW-1:0]      tag_map [TAG_RANGE];
    logic [TAG_AW-1:0]      in_tag;
    logic                   hist_we;
    logic [HIST_AW-1:0]     hist_waddr;
    logic [COUNT_WIDTH-1:0] hist_wdata;
    logic [HIST_AW-1:0]     hist_raddr;
    logic [COUNT_WIDTH-1:0] hist_rdata;
    logic [COUNT_WIDTH-1:0] count_inc;

    logic [DEVICE_SLOTS-1:0] slot_valid_reg;
    logic [DEVICE_W-1:0]     slot_device_reg [DEVICE_SLOTS];

    // Input read-out fields
    logic                rd_ok;
    logic [SLOT_W-1:0]   rd_slot;
    logic [HIST_AW-1:0]  rd_hist_addr;

    // Transaction registers
    logic [1:0]          mode_reg;
    logic [TAG_AW-1:0]   tag_reg;
    logic                op_rw_reg;
    logic                op_dir_reg;
    logic [DEVICE_W-1:0] device_reg;
    logic [TIME_W-1:0]   time_reg;
    logic                partial_reg;
    logic                rd_ok_reg;
    logic [SLOT_W-1:0]   rd_slot_reg;

    logic                    completes;
    logic [DEVICE_W-1:0]     cmp_dev_reg;
    logic                    dir_reg;
    logic [TIME_W-1:0]       diff_reg;
    logic [DEVICE_SLOTS-1:0] match_vec, match_reg;
    logic [DEVICE_SLOTS-1:0] free_vec, free_reg;
    logic                    match_hit, free_hit, slot_found;
    logic [SLOT_W-1:0]       match_idx, free_idx, slot_sel;
    logic [BUCKET_W-1:0]     bucket_calc, bucket_reg;
    logic [HIST_AW-1:0]      scan_addr, hist_addr_reg;

    // Pending result and output register
    status_t                res_status_reg;
    logic [BUCKET_IN_W-1:0] res_bucket_reg;
    logic [VALUE_W-1:0]     res_count_reg;
    logic                   res_inuse_reg;
    logic [MAJOR_W-1:0]     res_major_reg;
    logic [MINOR_W-1:0]     res_minor_reg;

    logic                   out_valid_reg;
    status_t                out_status_reg;
    logic [BUCKET_IN_W-1:0] out_bucket_reg;
    logic [VALUE_W-1:0]     out_count_reg;
    logic                   out_inuse_reg;
    logic [MAJOR_W-1:0]     out_major_reg;
    logic [MINOR_W-1:0]     out_minor_reg;

    // Tags wider than the table fold back modulo TAG_COUNT through a constant table.
    for (genvar g = 0; g < TAG_RANGE; g++)
    begin : g_tag_map
        assign tag_map[g] = TAG_AW'(g % TAG_COUNT);
    end
    assign in_tag = tag_map[request_tag];

    assign rd_ok        = (read_slot < DEVICE_SLOTS) && (read_bucket < BUCKET_COUNT);
    assign rd_slot      = SLOT_W'(read_slot);
    assign rd_hist_addr = hist_index(rd_slot, read_direction, BUCKET_W'(read_bucket));

    assign out_free  = !out_valid_reg || out_ready;
    assign accept    = in_valid && ready_c;
    assign completes = (mode_reg == MODE_COMPLETE) && start_rdata.valid && !partial_reg;
    assign count_inc = (&hist_rdata) ? hist_rdata : hist_rdata + COUNT_WIDTH'(1);

    iolh_ram #(
        .WIDTH (REC_W),
        .DEPTH (TAG_COUNT)
    ) u_start_ram (
        .clk   (clk),
        .we    (start_we),
        .waddr (start_waddr),
        .wdata (start_wdata),
        .raddr (in_tag),
        .rdata (start_rdata)
    );

    iolh_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (HIST_DEPTH)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    // Slot search against the record's device, registered before encoding.
    always_comb
    begin
        for (int i = 0; i < DEVICE_SLOTS; i++)
        begin
            match_vec[i] = slot_valid_reg[i] && (slot_device_reg[i] == start_rdata.device);
            free_vec[i]  = !slot_valid_reg[i];
        end
    end

    always_comb
    begin
        match_hit = 1'b0;
        match_idx = '0;
        free_hit  = 1'b0;
        free_idx  = '0;
        for (int i = DEVICE_SLOTS - 1; i >= 0; i--)
        begin
            if (match_reg[i])
            begin
                match_hit = 1'b1;
                match_idx = SLOT_W'(i);
            end
            if (free_reg[i])
            begin
                free_hit = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
    end

    assign slot_found = match_hit || free_hit;
    assign slot_sel   = match_hit ? match_idx : free_idx;

    // floor(log2(ns / 1000)) >= k exactly when (ns >> k) >= 1000; the
    // thresholds rise with k, so the last one met is the bucket.
    always_comb
    begin
        bucket_calc = '0;
        for (int k = 1; k < BUCKET_COUNT; k++)
        begin
            if ((diff_reg >> k) >= NS_PER_US)
            begin
                bucket_calc = BUCKET_W'(k);
            end
        end
    end

    assign scan_addr = hist_index(slot_sel, dir_reg, bucket_calc);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_CLEAR:
            begin
                if (clr_addr_reg == CLR_W'(CLR_DEPTH - 1))
                begin
                    state_next = FSM_IDLE;
                end
            end
            FSM_IDLE:
            begin
                if (accept)
                begin
                    state_next = FSM_LOOKUP;
                end
            end
            FSM_LOOKUP:
            begin
                state_next = completes ? FSM_SCAN : FSM_FINISH;
            end
            FSM_SCAN:
            begin
                state_next = slot_found ? FSM_COUNT : FSM_FINISH;
            end
            FSM_COUNT:
            begin
                state_next = FSM_FINISH;
            end
            FSM_FINISH:
            begin
                if (out_free)
                begin
                    state_next = accept ? FSM_LOOKUP : FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_CLEAR;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        ready_c     = 1'b0;
        load_out    = 1'b0;
        start_we    = 1'b0;
        start_waddr = tag_reg;
        start_wdata = '0;
        hist_we     = 1'b0;
        hist_waddr  = hist_addr_reg;
        hist_wdata  = count_inc;
        hist_raddr  = rd_hist_addr;
        unique case (state_reg)
            FSM_CLEAR:
            begin
                start_we    = (clr_addr_reg < TAG_COUNT);
                start_waddr = TAG_AW'(clr_addr_reg);
                hist_we     = (clr_addr_reg < HIST_DEPTH);
                hist_waddr  = HIST_AW'(clr_addr_reg);
                hist_wdata  = '0;
            end
            FSM_IDLE:
            begin
                ready_c = 1'b1;
            end
            FSM_LOOKUP:
            begin
                if ((mode_reg == MODE_ISSUE) && op_rw_reg)
                begin
                    start_we                = 1'b1;
                    start_wdata.valid       = 1'b1;
                    start_wdata.direction   = op_dir_reg;
                    start_wdata.device      = device_reg;
                    start_wdata.start_ns    = time_reg;
                end
                else if (completes)
                begin
                    // The record is released whether or not a slot is found.
                    start_we = 1'b1;
                end
            end
            FSM_SCAN:
            begin
                hist_raddr = scan_addr;
            end
            FSM_COUNT:
            begin
                hist_we = 1'b1;
            end
            FSM_FINISH:
            begin
                load_out = out_free;
                ready_c  = out_free;
            end
            default:
            begin
                ready_c = 1'b0;
            end
        endcase
    end

    assign in_ready = ready_c;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= FSM_CLEAR;
            clr_addr_reg   <= '0;
            out_valid_reg  <= 1'b0;
            slot_valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == FSM_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + CLR_W'(1);
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if ((state_reg == FSM_SCAN) && !match_hit && free_hit)
            begin
                slot_valid_reg[free_idx] <= 1'b1;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg    <= mode;
            tag_reg     <= in_tag;
            op_rw_reg   <= (op_flags[7:0] == OP_READ) || (op_flags[7:0] == OP_WRITE);
            op_dir_reg  <= (op_flags[7:0] == OP_WRITE);
            device_reg  <= {device_major, device_minor};
            time_reg    <= time_ns;
            partial_reg <= (completed_bytes < remaining_bytes);
            rd_ok_reg   <= rd_ok;
            rd_slot_reg <= rd_slot;
        end

        unique case (state_reg)
            FSM_LOOKUP:
            begin
                res_status_reg <= ST_IGNORED;
                res_bucket_reg <= '0;
                res_count_reg  <= '0;
                res_inuse_reg  <= 1'b0;
                res_major_reg  <= '0;
                res_minor_reg  <= '0;
                cmp_dev_reg    <= start_rdata.device;
                dir_reg        <= start_rdata.direction;
                diff_reg       <= time_reg - start_rdata.start_ns;
                match_reg      <= match_vec;
                free_reg       <= free_vec;
                case (mode_reg)
                    MODE_ISSUE:
                    begin
                        res_status_reg <= op_rw_reg ? ST_STARTED : ST_IGNORED;
                    end
                    MODE_COMPLETE:
                    begin
                        if (!start_rdata.valid)
                        begin
                            res_status_reg <= ST_NO_START;
                        end
                        else if (partial_reg)
                        begin
                            res_status_reg <= ST_PARTIAL;
                        end
                    end
                    MODE_READ:
                    begin
                        res_status_reg <= ST_READ_DONE;
                        if (rd_ok_reg)
                        begin
                            res_count_reg <= VALUE_W'(hist_rdata);
                            if (slot_valid_reg[rd_slot_reg])
                            begin
                                res_inuse_reg <= 1'b1;
                                {res_major_reg, res_minor_reg} <= slot_device_reg[rd_slot_reg];
                            end
                        end
                    end
                    default:
                    begin
                        res_status_reg <= ST_IGNORED;
                    end
                endcase
            end
            FSM_SCAN:
            begin
                bucket_reg    <= bucket_calc;
                hist_addr_reg <= scan_addr;
                if (!slot_found)
                begin
                    res_status_reg <= ST_FULL;
                    res_bucket_reg <= '0;
                    res_count_reg  <= '0;
                    res_inuse_reg  <= 1'b0;
                    res_major_reg  <= '0;
                    res_minor_reg  <= '0;
                end
                else if (!match_hit)
                begin
                    slot_device_reg[free_idx] <= cmp_dev_reg;
                end
            end
            FSM_COUNT:
            begin
                res_status_reg <= ST_COUNTED;
                res_bucket_reg <= BUCKET_IN_W'(bucket_reg);
                res_count_reg  <= VALUE_W'(count_inc);
                res_inuse_reg  <= 1'b0;
                res_major_reg  <= '0;
                res_minor_reg  <= '0;
            end
            default:
            begin
            end
        endcase

        if (load_out)
        begin
            out_status_reg <= res_status_reg;
            out_bucket_reg <= res_bucket_reg;
            out_count_reg  <= res_count_reg;
            out_inuse_reg  <= res_inuse_reg;
            out_major_reg  <= res_major_reg;
            out_minor_reg  <= res_minor_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign bucket_index = out_bucket_reg;
    assign count_value  = out_count_reg;
    assign slot_in_use  = out_inuse_reg;
    assign slot_major   = out_major_reg;
    assign slot_minor   = out_minor_reg;

endmodule

### hw/rtl/iolh_ram.sv
// ----------------------------------------------------------------------------
// iolh_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module iolh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/iolh_checker.sv
// ----------------------------------------------------------------------------
// iolh_checker: port-level checks of the I/O latency histogram
// Watches the top-level ports only and is bound to every instance.
// ----------------------------------------------------------------------------
module iolh_checker
    import iolh_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [2:0]             status,
    input logic [BUCKET_IN_W-1:0] bucket_index,
    input logic [VALUE_W-1:0]     count_value,
    input logic                   slot_in_use,
    input logic [MAJOR_W-1:0]     slot_major,
    input logic [MINOR_W-1:0]     slot_minor
);

    // One transaction is worked on at a time, so ready drops right after an accept.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("in_ready stayed high after an accepted transaction");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(count_value)
            && $stable(bucket_index))
        else $error("stalled result changed");

    a_bucket_only_counted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_COUNTED) |-> bucket_index == '0)
        else $error("bucket index set on a result that was not counted");

    a_slot_only_read: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_READ_DONE) |-> !slot_in_use && (slot_major == '0)
            && (slot_minor == '0))
        else $error("slot fields set on a result that was not a counter read");

    a_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_COUNTED) && (status != ST_READ_DONE) |-> count_value == '0)
        else $error("count value set on a result without a counter");

endmodule

bind io_latency_log2_histogram iolh_checker u_iolh_checker (.*);
